// ===== design/sfr_pkg.sv =====
// Package for the stream find-and-replace block: item types, configuration and helpers.
package sfr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam logic [2:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [2:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [2:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [2:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [2:0] CSR_IGNORE_CASE        = 3'd4;
   localparam logic [2:0] CSR_TARGET_LINE        = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       newline;
   } cls_item_type;

   typedef struct packed {
      logic [63:0] pattern_bytes;
      logic [3:0]  pattern_length;
      logic [63:0] replacement_bytes;
      logic [3:0]  replacement_length;
      logic        ignore_case;
      logic [31:0] target_line;
   } cfg_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b, input logic ic);
      logic [7:0] r;
      r = b;
      if (ic && (b >= 8'h41) && (b <= 8'h5A)) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

endpackage

// ===== design/stream_find_replace.sv =====
// Top level of the streaming find-and-replace block.
// Sequence: the back part takes an item from the request queue while idle, then passes,
// scans or flushes the held bytes, detects a match and replaces it, ends the scan, ends a
// flush and closes the item.
// Throughput is one item at a time, set by the back part's match sequencer; a full result
// queue stalls it. Synchronous active-high reset empties both queues, clears the held partial
// match and sets the line counter to one; configuration returns to defaults.
module stream_find_replace import sfr_pkg::*; #(
   parameter int REQ_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   cfg_type      cfg_ff;
   logic         q_pop, q_empty;
   cls_item_type q_item;

   // Configuration is always ready; it is only to be written while no item is in flight.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes      <= '0;
         cfg_ff.pattern_length     <= 4'd1;
         cfg_ff.replacement_bytes  <= '0;
         cfg_ff.replacement_length <= '0;
         cfg_ff.ignore_case        <= 1'b0;
         cfg_ff.target_line        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      cfg_ff.pattern_bytes      <= csr_wdata;
            CSR_PATTERN_LENGTH:     cfg_ff.pattern_length     <= csr_wdata[3:0];
            CSR_REPLACEMENT_BYTES:  cfg_ff.replacement_bytes  <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_ff.replacement_length <= csr_wdata[3:0];
            CSR_IGNORE_CASE:        cfg_ff.ignore_case        <= csr_wdata[0];
            CSR_TARGET_LINE:        cfg_ff.target_line        <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // The front part classifies and queues items; the back part rewrites them.
   sfr_front #(.DEPTH(REQ_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_full (full),
      .req_item (req_item),
      .q_pop    (q_pop),
      .q_empty  (q_empty),
      .q_item   (q_item)
   );

   sfr_back #(.DEPTH(RSP_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_item  (rsp_item)
   );
endmodule

// ===== design/sfr_fifo.sv =====
// Small register queue used between the parts of the block.
module sfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end
endmodule

// ===== design/sfr_front.sv =====
// Front part: accepts items, marks newlines and queues them for the back part.
module sfr_front import sfr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_item_type req_item,
   input  logic         q_pop,
   output logic         q_empty,
   output cls_item_type q_item
);
   cls_item_type cls;

   always_comb begin
      cls.data_byte     = req_item.data_byte;
      cls.end_of_stream = req_item.end_of_stream;
      cls.newline       = (req_item.data_byte == NEWLINE_BYTE);
   end

   sfr_fifo #(.WIDTH($bits(cls_item_type)), .DEPTH(DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_item),
      .empty (q_empty)
   );
endmodule

// ===== design/sfr_back.sv =====
// Back part: match sequencer, replacement and flush, feeding the result queue.
module sfr_back import sfr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_empty,
   input  cls_item_type q_item,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_item_type rsp_item
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_REPL  = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]  state_ff;
   logic [7:0]  buf_ff [8];
   logic [3:0]  rem_ff, pcnt_ff, n_ff;
   logic [2:0]  cnt_ff;
   logic        pass_ff, flush_ff;
   logic [31:0] line_ff;
   logic [7:0]  held_ff;
   logic        held_v_ff;

   logic [3:0]  plen, rlen, span;
   logic [7:0]  fpat [8];
   logic        prefix_k, full_m, part_m, active;
   logic        emit_req, do_emit, stall, shift, out_full, out_push;
   logic [7:0]  emit_byte;
   rsp_item_type out_item;

   always_comb begin
      plen = cfg.pattern_length;
      if (plen == 4'd0) begin
         plen = 4'd1;
      end else if (plen > 4'(MAX_PATTERN)) begin
         plen = 4'(MAX_PATTERN);
      end
      rlen = (cfg.replacement_length > 4'(MAX_REPLACEMENT)) ?
             4'(MAX_REPLACEMENT) : cfg.replacement_length;
      span = (rlen > plen) ? rlen : plen;
      active = (cfg.target_line == 32'd0) || (line_ff == cfg.target_line);
      prefix_k = 1'b1;
      full_m   = 1'b1;
      part_m   = 1'b1;
      for (int i = 0; i < 8; i++) begin
         fpat[i] = fold_case(cfg.pattern_bytes[i*8 +: 8], cfg.ignore_case);
         if ((4'(i) < pcnt_ff) && (fold_case(buf_ff[i], cfg.ignore_case) != fpat[i])) begin
            prefix_k = 1'b0;
         end
         if (fold_case(buf_ff[i], cfg.ignore_case) != fpat[i]) begin
            if (4'(i) < plen) full_m = 1'b0;
            if (4'(i) < rem_ff) part_m = 1'b0;
         end
      end
   end

   // Emission request and the byte it carries, per state.
   always_comb begin
      emit_req  = 1'b0;
      emit_byte = buf_ff[0];
      shift     = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            if (pass_ff) begin
               emit_req = (rem_ff != 4'd0);
            end else if (!((rem_ff >= plen) && full_m) && !((rem_ff < plen) && part_m)) begin
               emit_req = 1'b1;
            end
            shift = emit_req;
         end
         ST_REPL: begin
            emit_req  = ({1'b0, cnt_ff} < rlen);
            emit_byte = cfg.replacement_bytes[{cnt_ff, 3'b000} +: 8];
            shift     = ({1'b0, cnt_ff} < plen);
         end
         ST_FLUSH: begin
            emit_req = (rem_ff != 4'd0);
            shift    = emit_req;
         end
         default: begin
         end
      endcase
      do_emit  = emit_req && (n_ff < 4'd8);
      stall    = do_emit && held_v_ff && out_full;
      out_push = (do_emit && held_v_ff && !stall) ||
                 ((state_ff == ST_FIN) && held_v_ff && !out_full);
      out_item.out_byte = held_ff;
      out_item.run_last = (state_ff == ST_FIN);
      q_pop = (state_ff == ST_IDLE) && !q_empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pcnt_ff   <= '0;
         rem_ff    <= '0;
         n_ff      <= '0;
         cnt_ff    <= '0;
         pass_ff   <= 1'b0;
         flush_ff  <= 1'b0;
         line_ff   <= 32'd1;
         held_v_ff <= 1'b0;
      end else if (!stall) begin
         if (do_emit) begin
            held_v_ff <= 1'b1;
            n_ff      <= n_ff + 4'd1;
         end
         if (shift) begin
            rem_ff <= rem_ff - 4'd1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  rem_ff   <= pcnt_ff + 4'd1;
                  pass_ff  <= !active || (pcnt_ff >= plen) || !prefix_k;
                  flush_ff <= q_item.newline || q_item.end_of_stream;
                  n_ff     <= '0;
                  state_ff <= ST_SCAN;
                  if (q_item.end_of_stream) begin
                     line_ff <= 32'd1;
                  end else if (q_item.newline && (line_ff != '1)) begin
                     line_ff <= line_ff + 32'd1;
                  end
               end
            end
            ST_SCAN: begin
               if (pass_ff) begin
                  if (rem_ff == 4'd0) begin
                     pcnt_ff  <= '0;
                     state_ff <= ST_FIN;
                  end
               end else if ((rem_ff >= plen) && full_m) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_REPL;
               end else if ((rem_ff < plen) && part_m) begin
                  pcnt_ff  <= rem_ff;
                  state_ff <= flush_ff ? ST_FLUSH : ST_FIN;
               end
            end
            ST_REPL: begin
               cnt_ff <= cnt_ff + 3'd1;
               if ({1'b0, cnt_ff} + 4'd1 >= span) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_FLUSH: begin
               if (rem_ff == 4'd0) begin
                  pcnt_ff  <= '0;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!held_v_ff || !out_full) begin
                  held_v_ff <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         if (do_emit) begin
            held_ff <= emit_byte;
         end
         if ((state_ff == ST_IDLE) && !q_empty) begin
            buf_ff[pcnt_ff[2:0]] <= q_item.data_byte;
         end else if (shift) begin
            for (int i = 0; i < 7; i++) begin
               buf_ff[i] <= buf_ff[i+1];
            end
         end
      end
   end

   sfr_fifo #(.WIDTH($bits(rsp_item_type)), .DEPTH(DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_item),
      .empty (rsp_empty)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_v_ff)
      else $error("held result survives the end of an item");
   assert property (@(posedge clock) disable iff (reset)
      (rem_ff <= 4'd8) && (pcnt_ff <= 4'd7))
      else $error("buffer fill out of range");
   assert property (@(posedge clock) disable iff (reset)
      n_ff <= 4'd8)
      else $error("more than eight results for one item");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SCAN))
      else $error("item taken without starting a scan");
`endif
endmodule

// ===== tb/tb_stream_find_replace.sv =====
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 100ps

module tb_stream_find_replace;
   import sfr_pkg::*;

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   req_item_type req_item;
   logic         empty;
   logic         pop;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   stream_find_replace i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The testbench's own copy of the configuration and of the matcher state.
   logic [63:0] find_bytes;
   logic [3:0]  find_len;
   logic [63:0] subst_bytes;
   logic [3:0]  subst_len;
   logic        fold_on;
   logic [31:0] only_line;
   logic [7:0]  held [8];
   int unsigned held_count;
   logic [31:0] line_no;

   // Rewritten bytes still to come from the block, oldest first.
   rsp_item_type rewritten_q[$];
   int           error_count;
   int           items_sent;
   int           bytes_seen;
   int           line_items;
   bit           stall_pop;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Generous limit: 250+ items, each with a random gap before it.
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] lower_letter(input logic [7:0] b);
      if (fold_on && b >= "A" && b <= "Z") begin
         return b + 8'd32;
      end
      return b;
   endfunction

   function automatic int unsigned find_len_used();
      if (find_len == 4'd0) begin
         return 1;
      end
      return (find_len > 4'd8) ? 8 : find_len;
   endfunction

   // True when the n bytes of scan starting at pos agree with the pattern head.
   function automatic bit agrees(input logic [7:0] scan [9], input int unsigned pos,
                                 input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (lower_letter(scan[pos + i]) != lower_letter(find_bytes[i*8 +: 8])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Works out the rewritten bytes that one input item causes.
   task automatic rewrite_byte(input req_item_type it);
      logic [7:0]   scan [9];
      rsp_item_type out_list[$];
      rsp_item_type one;
      int unsigned  plen, rlen, count, pos, rest;
      bit           live;
      plen = find_len_used();
      rlen = (subst_len > 4'd8) ? 8 : subst_len;
      live = (only_line == 32'd0) || (line_no == only_line);
      for (int unsigned i = 0; i < held_count; i++) begin
         scan[i] = held[i];
      end
      scan[held_count] = it.data_byte;
      count = held_count + 1;
      one.run_last = 1'b0;
      if (!live || held_count >= plen || !agrees(scan, 0, held_count)) begin
         // Stale or untargeted: everything held goes out untouched.
         for (int unsigned i = 0; i < count; i++) begin
            one.out_byte = scan[i];
            out_list.push_back(one);
         end
         held_count = 0;
      end else begin
         pos = 0;
         while (pos < count) begin
            rest = count - pos;
            if (rest >= plen && agrees(scan, pos, plen)) begin
               for (int unsigned i = 0; i < rlen; i++) begin
                  one.out_byte = subst_bytes[i*8 +: 8];
                  out_list.push_back(one);
               end
               pos += plen;
            end else if (rest < plen && agrees(scan, pos, rest)) begin
               break;
            end else begin
               one.out_byte = scan[pos];
               out_list.push_back(one);
               pos++;
            end
         end
         held_count = count - pos;
         for (int unsigned i = 0; i < held_count; i++) begin
            held[i] = scan[pos + i];
         end
      end
      if (it.data_byte == NEWLINE_BYTE || it.end_of_stream) begin
         for (int unsigned i = 0; i < held_count; i++) begin
            one.out_byte = held[i];
            out_list.push_back(one);
         end
         held_count = 0;
      end
      if (it.data_byte == NEWLINE_BYTE && line_no != 32'hFFFF_FFFF) begin
         line_no++;
      end
      if (it.end_of_stream) begin
         line_no = 32'd1;
      end
      // The block never emits more than eight bytes for one item.
      while (out_list.size() > 8) begin
         void'(out_list.pop_back());
      end
      if (out_list.size() > 0) begin
         out_list[out_list.size() - 1].run_last = 1'b1;
      end
      foreach (out_list[i]) begin
         rewritten_q.push_back(out_list[i]);
      end
   endtask

   // Sends one item; the expectation is recorded at the accepting edge.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = gap_length();
      repeat (gap) @(posedge clock);
      push     <= 1'b1;
      req_item <= '{data_byte: b, end_of_stream: eos};
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      rewrite_byte('{data_byte: b, end_of_stream: eos});
      items_sent++;
      if (b == NEWLINE_BYTE) begin
         line_items++;
      end
      push <= 1'b0;
      @(posedge clock);
   endtask

   // Sends every character of a text as an item of its own.
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], 1'b0);
      end
   endtask

   // Waits for every expected byte, then lets the block settle.
   task automatic drain();
      while (rewritten_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         CSR_PATTERN_BYTES:      find_bytes  = value;
         CSR_PATTERN_LENGTH:     find_len    = value[3:0];
         CSR_REPLACEMENT_BYTES:  subst_bytes = value;
         CSR_REPLACEMENT_LENGTH: subst_len   = value[3:0];
         CSR_IGNORE_CASE:        fold_on     = value[0];
         CSR_TARGET_LINE:        only_line   = value[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Sets up a whole rule in one go; pattern text is given first byte lowest.
   task automatic set_rule(input logic [63:0] pat, input int plen, input logic [63:0] rep,
                           input int rlen, input bit fold, input logic [31:0] line);
      drain();
      write_reg(CSR_PATTERN_BYTES, pat);
      write_reg(CSR_PATTERN_LENGTH, 64'(plen));
      write_reg(CSR_REPLACEMENT_BYTES, rep);
      write_reg(CSR_REPLACEMENT_LENGTH, 64'(rlen));
      write_reg(CSR_IGNORE_CASE, 64'(fold));
      write_reg(CSR_TARGET_LINE, 64'(line));
   endtask

   // Results side: random back-pressure, field-by-field comparison.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (pop && !empty) begin
            bytes_seen++;
            if (rewritten_q.size() == 0) begin
               $error("unexpected byte: out_byte actual %h", rsp_item.out_byte);
               error_count++;
            end else begin
               want = rewritten_q.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte,
                         rsp_item.out_byte);
                  error_count++;
               end
               if (rsp_item.run_last !== want.run_last) begin
                  $error("run_last: expected %b, actual %b", want.run_last,
                         rsp_item.run_last);
                  error_count++;
               end
            end
         end
         pop <= stall_pop ? 1'b0 : ($urandom_range(0, 9) != 0);
      end
   end

   // Stall pattern for pop: quiet phases, busy phases and long holds.
   initial begin
      stall_pop = 1'b0;
      forever begin
         repeat ($urandom_range(20, 200)) @(posedge clock);
         stall_pop = ($urandom_range(0, 3) == 0);
         if (stall_pop) begin
            repeat (gap_length() + 5) @(posedge clock);
            stall_pop = 1'b0;
         end
      end
   end

   // Random text leaning on the pattern so that matches are frequent.
   function automatic logic [7:0] pick_byte();
      int roll;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         b = find_bytes[$urandom_range(0, find_len_used() - 1)*8 +: 8];
         if (fold_on && $urandom_range(0, 1) && b >= "a" && b <= "z") begin
            b = b - 8'd32;
         end
      end else if (roll < 65) begin
         b = NEWLINE_BYTE;
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   task automatic test_reset_defaults();
      // After reset the pattern is one zero byte and the replacement empty.
      send_byte(8'h00, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_directed();
      // "abc" to "XY" in every line.
      set_rule(64'h63_62_61, 3, 64'h59_58, 2, 1'b0, 32'd0);
      send_text("zabcab");
      send_byte(NEWLINE_BYTE, 1'b0);       // partial match flushed at newline
      send_byte("a", 1'b0);
      send_byte("b", 1'b1);                // partial match flushed at end
      // Case folding, deleting replacement, and an overlapping near miss.
      set_rule(64'h61_61, 2, 64'h0, 0, 1'b1, 32'd0);
      send_byte("A", 1'b0);
      send_byte("a", 1'b0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b1);
      // Pattern length zero acts as one; lengths above eight saturate.
      set_rule(64'h0A, 0, 64'hFFEEDDCCBBAA9988, 15, 1'b0, 32'd0);
      send_byte(NEWLINE_BYTE, 1'b0);
      send_byte(8'h80, 1'b1);
      // Full-length pattern and replacement, only on line two.
      set_rule(64'h68_67_66_65_64_63_62_61, 8, 64'h0123456789ABCDEF, 8, 1'b0, 32'd2);
      send_text("abcdefgh");
      send_byte(NEWLINE_BYTE, 1'b0);
      send_text("abcdefgh");
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_stale_prefix();
      // Hold a partial match, then change the pattern under it.
      set_rule(64'h71_70, 2, 64'h21, 1, 1'b0, 32'd0);
      send_byte("p", 1'b0);
      drain();
      write_reg(CSR_PATTERN_BYTES, 64'h73_72);
      send_byte("s", 1'b1);
   endtask

   task automatic test_line_saturation();
      // Target the last line number, which this short stream never reaches.
      set_rule(64'h0A, 1, 64'h2A, 1, 1'b0, 32'hFFFF_FFFF);
      send_byte(NEWLINE_BYTE, 1'b1);
   endtask

   task automatic test_random_text();
      for (int phase = 0; phase < 10; phase++) begin
         set_rule({$urandom, $urandom}, $urandom_range(0, 15),
                  {$urandom, $urandom}, $urandom_range(0, 15),
                  1'($urandom_range(0, 1)),
                  ($urandom_range(0, 2) == 0) ? 32'($urandom_range(1, 4)) : 32'd0);
         // Readable text in most phases, so that letters and case meet.
         if (phase % 3 != 2) begin
            for (int i = 0; i < 8; i++) begin
               find_bytes[i*8 +: 8] = 8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 3)
                                                              : "A" + $urandom_range(0, 3));
            end
            drain();
            write_reg(CSR_PATTERN_BYTES, find_bytes);
         end
         for (int i = 0; i < 25; i++) begin
            send_byte(pick_byte(), ($urandom_range(0, 19) == 0) || i == 24);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PATTERN_BYTES;
      csr_wdata = '0;
      find_bytes = '0;
      find_len = 4'd1;
      subst_bytes = '0;
      subst_len = 4'd0;
      fold_on = 1'b0;
      only_line = '0;
      held_count = 0;
      line_no = 32'd1;
      error_count = 0;
      items_sent = 0;
      bytes_seen = 0;
      line_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_stale_prefix();
      test_line_saturation();
      test_random_text();
      drain();
      $display("Sent %0d items (%0d newlines) over many rules; checked %0d rewritten bytes.",
               items_sent, line_items, bytes_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
